// ===== src/txdr_pkg.sv =====
// ----------------------------------------------------------------------------
// txdr_pkg: shared types and constants
// Types, codes and fixed constants of the transmit descriptor ring block.
// ----------------------------------------------------------------------------
`default_nettype none

package txdr_pkg;

   localparam int SLOT_W  = 9;
   localparam int ADDR_W  = 64;
   localparam int LEN_W   = 16;
   localparam int CTRL_W  = 32;
   localparam int COUNT_W = 7;
   localparam int QID_W   = 8;
   localparam int LG_W    = 4;
   localparam int SCAN_W  = 6;

   // Command bits of a descriptor: end of packet, insert FCS, report status.
   localparam logic [CTRL_W-1:0] CMD_BITS = 32'h0B00_0000;

   localparam logic [LG_W-1:0]    RING_LG_MIN = 4'd6;
   localparam logic [LG_W-1:0]    RING_LG_MAX = 4'd9;
   localparam logic [COUNT_W-1:0] BATCH_MIN   = 7'd16;
   localparam logic [COUNT_W-1:0] BATCH_MAX   = 7'd64;

   localparam logic [0:0] CSR_RING_SIZE_LOG2 = 1'b0;
   localparam logic [0:0] CSR_CLEAN_BATCH    = 1'b1;

   typedef enum logic [1:0] {
      ACT_SUBMIT = 2'd0,
      ACT_DONE   = 2'd1,
      ACT_CALL   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_BATCH   = 2'd0,
      KIND_DESC    = 2'd1,
      KIND_TAIL    = 2'd2,
      KIND_REFUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_SET,
      OP_REFUSE,
      OP_CALL
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                do_clean;
      logic                do_pkt;
      logic                do_tail;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    len;
      logic [SLOT_W-1:0]   didx;
   } item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  mask;
      logic [COUNT_W-1:0] batch;
   } cfg_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   addr;
      logic [CTRL_W-1:0]   ctrl;
      logic [COUNT_W-1:0]  freed;
      logic                err;
      logic                last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET,
      ST_REFUSE,
      ST_CL_START,
      ST_CL_TEST,
      ST_CL_END,
      ST_CL_SCAN,
      ST_CL_EMIT,
      ST_PKT,
      ST_TAIL
   } back_state_type;

   localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ===== src/txdr_front.sv =====
// ----------------------------------------------------------------------------
// txdr_front: request intake
// Accepts requests, drops the no-op action and classifies the rest into
// queue items for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module txdr_front
   import txdr_pkg::*;
(
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_action,
   input  wire logic [QID_W-1:0]    req_queue_sel,
   input  wire logic                req_batch_start,
   input  wire logic                req_batch_end,
   input  wire logic [ADDR_W-1:0]   req_buffer_address,
   input  wire logic [LEN_W-1:0]    req_packet_length,
   input  wire logic [SLOT_W-1:0]   req_done_index,
   output logic                     req_ready,
   input  wire logic                q_full,
   input  wire logic                init_busy,
   output logic                     push,
   output item_type                 push_item
);

   action_type action;

   assign action    = action_type'(req_action);
   assign req_ready = !q_full && !init_busy;
   assign push      = req_valid && req_ready && (action != ACT_NONE);

   always_comb begin
      push_item          = '0;
      push_item.addr     = req_buffer_address;
      push_item.len      = req_packet_length;
      push_item.didx     = req_done_index;
      push_item.do_clean = (action == ACT_CALL) || req_batch_start;
      push_item.do_pkt   = (action == ACT_SUBMIT);
      push_item.do_tail  = (action == ACT_CALL) || req_batch_end;
      unique case (action)
         ACT_DONE: begin
            push_item.op = OP_SET;
         end
         ACT_SUBMIT, ACT_CALL: begin
            // Only queue zero exists; any other queue is refused outright.
            push_item.op = (req_queue_sel != '0) ? OP_REFUSE : OP_CALL;
         end
         default: begin
            push_item.op = OP_SET;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/txdr_queue.sv =====
// ----------------------------------------------------------------------------
// txdr_queue: item queue
// Short FIFO between the intake and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module txdr_queue
   import txdr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  item_type       push_item,
   input  wire logic      pop,
   output logic           q_full,
   output logic           q_valid,
   output item_type       q_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff,  count_in;

   assign q_full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/txdr_back.sv =====
// ----------------------------------------------------------------------------
// txdr_back: ring sequencer
// Holds the done-bit memory and the tail and clean indices, and carries out
// done write-backs, batched cleanup, packet queueing and tail reports.
// ----------------------------------------------------------------------------
`default_nettype none

module txdr_back
   import txdr_pkg::*;
#(
   parameter int RING_DEPTH = 512
)(
   input  wire logic      clock,
   input  wire logic      reset,
   input  cfg_type        cfg,
   input  wire logic      q_valid,
   input  item_type       q_item,
   output logic           q_pop,
   output logic           init_busy,
   input  wire logic      rsp_ready,
   output logic           rsp_valid,
   output rsp_type        rsp
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

   logic                  done_mem [RING_DEPTH];

   back_state_type        state_ff, state_in;
   item_type              cur_ff, cur_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic [SLOT_W-1:0]     clean_ff, clean_in;
   logic [SCAN_W-1:0]     k_ff, k_in;
   logic [COUNT_W-1:0]    freed_ff, freed_in;
   logic                  err_ff, err_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic                  rd_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  mem_we;
   logic                  mem_wdata;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;
   logic                  emit;
   rsp_type               emit_data;

   logic                  out_free;
   logic [SLOT_W-1:0]     tail_m, clean_m, inflight, end_slot, scan_slot, next_tail;
   logic                  enough, full, scan_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign tail_m    = tail_ff & cfg.mask;
   assign clean_m   = clean_ff & cfg.mask;
   assign inflight  = (tail_m - clean_m) & cfg.mask;
   assign enough    = (inflight >= SLOT_W'(cfg.batch));
   assign end_slot  = (clean_m + SLOT_W'(cfg.batch) - 9'd1) & cfg.mask;
   assign scan_slot = (clean_m + SLOT_W'(k_ff) + 9'd1) & cfg.mask;
   assign next_tail = (tail_m + 9'd1) & cfg.mask;
   assign full      = (clean_m == next_tail);
   assign scan_last = (k_ff == SCAN_W'(cfg.batch - 7'd1));

   assign init_busy = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  OP_SET:    state_in = ST_SET;
                  OP_REFUSE: state_in = ST_REFUSE;
                  default:   state_in = q_item.do_clean ? ST_CL_START : ST_PKT;
               endcase
            end
         end
         ST_SET: begin
            state_in = ST_IDLE;
         end
         ST_REFUSE: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_CL_START: begin
            state_in = ST_CL_TEST;
         end
         ST_CL_TEST: begin
            state_in = enough ? ST_CL_END : ST_PKT;
         end
         ST_CL_END: begin
            state_in = rd_ff ? ST_CL_SCAN : ST_PKT;
         end
         ST_CL_SCAN: begin
            if (!rd_ff || scan_last) state_in = ST_CL_EMIT;
         end
         ST_CL_EMIT: begin
            if (out_free) state_in = ST_CL_TEST;
         end
         ST_PKT: begin
            if (!cur_ff.do_pkt) begin
               state_in = ST_TAIL;
            end else if (out_free) begin
               state_in = cur_ff.do_tail ? ST_TAIL : ST_IDLE;
            end
         end
         ST_TAIL: begin
            if (!cur_ff.do_tail || out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      cur_in    = cur_ff;
      tail_in   = tail_ff;
      clean_in  = clean_ff;
      k_in      = k_ff;
      freed_in  = freed_ff;
      err_in    = err_ff;
      clr_in    = clr_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = 1'b0;
      mem_waddr = AW'(tail_m);
      mem_raddr = AW'(scan_slot);
      emit      = 1'b0;
      emit_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
            end
         end
         ST_SET: begin
            mem_we    = 1'b1;
            mem_wdata = 1'b1;
            mem_waddr = AW'(cur_ff.didx & cfg.mask);
         end
         ST_REFUSE: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.kind = KIND_REFUSED;
               emit_data.last = 1'b1;
            end
         end
         ST_CL_START: begin
            // Cleanup leaves both indices reduced to the current ring size.
            tail_in  = tail_m;
            clean_in = clean_m;
         end
         ST_CL_TEST: begin
            mem_raddr = AW'(end_slot);
         end
         ST_CL_END: begin
            mem_raddr = AW'(clean_m);
            k_in      = '0;
         end
         ST_CL_SCAN: begin
            if (!rd_ff) begin
               err_in   = 1'b1;
               freed_in = COUNT_W'(k_ff);
            end else if (scan_last) begin
               err_in   = 1'b0;
               freed_in = COUNT_W'(k_ff) + 7'd1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_CL_EMIT: begin
            if (out_free) begin
               emit            = 1'b1;
               emit_data.kind  = KIND_BATCH;
               emit_data.slot  = clean_m;
               emit_data.freed = freed_ff;
               emit_data.err   = err_ff;
               // The clean index skips the whole batch, even after an error.
               clean_in        = (clean_m + SLOT_W'(cfg.batch)) & cfg.mask;
            end
         end
         ST_PKT: begin
            if (cur_ff.do_pkt && out_free) begin
               emit           = 1'b1;
               emit_data.slot = tail_m;
               emit_data.last = !cur_ff.do_tail;
               if (full) begin
                  emit_data.kind = KIND_REFUSED;
               end else begin
                  emit_data.kind = KIND_DESC;
                  emit_data.addr = cur_ff.addr;
                  emit_data.ctrl = CTRL_W'(cur_ff.len) | CMD_BITS;
                  mem_we         = 1'b1;
                  tail_in        = next_tail;
               end
            end
         end
         ST_TAIL: begin
            if (cur_ff.do_tail && out_free) begin
               emit           = 1'b1;
               emit_data.kind = KIND_TAIL;
               emit_data.slot = tail_m;
               emit_data.last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         tail_ff      <= '0;
         clean_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tail_in;
         clean_ff <= clean_in;
         clr_ff   <= clr_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      k_ff     <= k_in;
      freed_ff <= freed_in;
      err_ff   <= err_in;
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         done_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= done_mem[mem_raddr];
   end

endmodule

`default_nettype wire

// ===== src/tx_descriptor_ring_batched_clean.sv =====
// ----------------------------------------------------------------------------
// tx_descriptor_ring_batched_clean: transmit ring with batched cleanup
// Top level: configuration registers, intake, item queue and ring sequencer.
// ----------------------------------------------------------------------------
// Requests enter on req_* (action in tuser, call end in tlast) and results
// leave on rsp_* (kind in tuser, final result of a request in tlast).
// Registers are to be written on csr_* only while the block is idle; the
// block does not enforce this, and csr_ready is always high. A two-entry
// queue sits between intake and sequencer, so the intake keeps taking
// requests while the sequencer works or waits. When the sequencer is idle,
// an accepted request passes through the queue and the sequencer's item
// register, and its first result is then registered in the output register.
// The sequencer handles a done write-back, a refused queue, a packet or a
// packet with tail report one request at a time; a call start adds cleanup.
// Each freed batch is scanned slot by slot, since the done bits are one
// memory with one read port; a batch whose last slot is not done yet ends
// the cleanup. After reset the done-bit memory is cleared one entry per
// cycle; req_tready stays low during that pass.
// A result waits in the output register while rsp_tready is low; the
// sequencer then holds, and the queue fills before req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tx_descriptor_ring_batched_clean
   import txdr_pkg::*;
#(
   parameter int RING_DEPTH = 512
)(
   input  wire logic           clock,
   input  wire logic           reset,
   // tdata: queue_sel[7:0], buffer_address[71:8], packet_length[87:72],
   //        done_index[96:88], zero[103:97]
   input  wire logic [103:0]   req_tdata,
   // tuser: action[1:0], batch_start[2]
   input  wire logic [2:0]     req_tuser,
   input  wire logic           req_tlast,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   // tdata: slot_index[8:0], descriptor_address[72:9],
   //        descriptor_control[104:73], freed_count[111:105],
   //        ring_error[112], zero[119:113]
   output logic [119:0]        rsp_tdata,
   // tuser: kind[1:0]
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [0:0]     csr_index,
   input  wire logic [6:0]     csr_data
);

   localparam int DEPTH_LG = $clog2(RING_DEPTH + 1) - 1;
   localparam int MAX_LG   = (DEPTH_LG < 9) ? DEPTH_LG : 9;

   logic [LG_W-1:0]     ring_lg_ff;
   logic [COUNT_W-1:0]  batch_ff;
   logic [LG_W-1:0]     lg_sat;
   cfg_type             cfg;

   logic                push, pop, q_full, q_valid, init_busy;
   item_type            push_item, q_item;
   logic                back_valid;
   rsp_type             back_rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_lg_ff <= RING_LG_MAX;
         batch_ff   <= 7'd32;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RING_SIZE_LOG2: ring_lg_ff <= csr_data[LG_W-1:0];
            CSR_CLEAN_BATCH:    batch_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (ring_lg_ff < RING_LG_MIN) begin
         lg_sat = RING_LG_MIN;
      end else if (ring_lg_ff > RING_LG_MAX) begin
         lg_sat = RING_LG_MAX;
      end else begin
         lg_sat = ring_lg_ff;
      end
      if (lg_sat > LG_W'(MAX_LG)) lg_sat = LG_W'(MAX_LG);
      cfg.mask = SLOT_W'((10'd1 << lg_sat) - 10'd1);
      if (batch_ff < BATCH_MIN) begin
         cfg.batch = BATCH_MIN;
      end else if (batch_ff > BATCH_MAX) begin
         cfg.batch = BATCH_MAX;
      end else begin
         cfg.batch = batch_ff;
      end
   end

   txdr_front u_front (
      .req_valid          (req_tvalid),
      .req_action         (req_tuser[1:0]),
      .req_queue_sel      (req_tdata[7:0]),
      .req_batch_start    (req_tuser[2]),
      .req_batch_end      (req_tlast),
      .req_buffer_address (req_tdata[71:8]),
      .req_packet_length  (req_tdata[87:72]),
      .req_done_index     (req_tdata[96:88]),
      .req_ready          (req_tready),
      .q_full             (q_full),
      .init_busy          (init_busy),
      .push               (push),
      .push_item          (push_item)
   );

   txdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_full    (q_full),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   txdr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (pop),
      .init_busy (init_busy),
      .rsp_ready (rsp_tready),
      .rsp_valid (back_valid),
      .rsp       (back_rsp)
   );

   assign rsp_tvalid = back_valid;
   assign rsp_tuser  = back_rsp.kind;
   assign rsp_tlast  = back_rsp.last;
   assign rsp_tdata  = {7'd0, back_rsp.err, back_rsp.freed, back_rsp.ctrl,
                        back_rsp.addr, back_rsp.slot};

`ifndef SYNTH
   // No request may enter while the done-bit memory is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !req_tready)
      else $error("request accepted during done-bit clearing");

   // A tail report always closes the results of its request.
   a_tail_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_TAIL) |-> rsp_tlast)
      else $error("tail report not marked last");

   // Freed batches never close a request: a packet or tail result follows.
   a_batch_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_BATCH) |-> !rsp_tlast)
      else $error("freed batch marked last");

   // Batch fields are zero on every other kind of result.
   a_batch_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_BATCH) |-> (rsp_tdata[112:105] == 8'd0))
      else $error("batch fields set on a non-batch result");
`endif

endmodule

`default_nettype wire

// ===== dv/txdr_ring_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txdr_ring_monitor: result checker for the transmit descriptor ring
// Watches the request, result and register channels. It keeps its own copy
// of the ring state, works out the results that each accepted request must
// produce, and compares every accepted result field by field in order.
// ----------------------------------------------------------------------------

module txdr_ring_monitor
   import txdr_pkg::*;
#(
   parameter int RING_DEPTH = 512
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [103:0]       req_tdata,
   input  wire logic [2:0]         req_tuser,
   input  wire logic               req_tlast,
   input  wire logic               req_tvalid,
   input  wire logic               req_tready,
   input  wire logic [119:0]       rsp_tdata,
   input  wire logic [1:0]         rsp_tuser,
   input  wire logic               rsp_tlast,
   input  wire logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [0:0]         csr_index,
   input  wire logic [6:0]         csr_data,
   output int                      fail_count,
   output int                      pending,
   output logic [SLOT_W-1:0]       ring_tail,
   output logic [SLOT_W-1:0]       ring_clean,
   output logic [SLOT_W-1:0]       ring_mask
);

   localparam logic [LG_W-1:0]    LG_AT_RESET    = 4'd9;
   localparam logic [COUNT_W-1:0] BATCH_AT_RESET = 7'd32;
   localparam int                 PRINT_LIMIT    = 30;

   logic               done_bits [RING_DEPTH];
   logic [SLOT_W-1:0]  tail_ptr;
   logic [SLOT_W-1:0]  clean_ptr;
   logic [LG_W-1:0]    size_log2_reg;
   logic [COUNT_W-1:0] batch_reg;

   rsp_type            ring_events_due [$];
   rsp_type            staged_event;
   int                 staged_count;

   function automatic logic [SLOT_W-1:0] slot_mask();
      int lg;
      int size;
      lg = size_log2_reg;
      if (lg < RING_LG_MIN) lg = RING_LG_MIN;
      if (lg > RING_LG_MAX) lg = RING_LG_MAX;
      size = 1 << lg;
      while (size > RING_DEPTH && size > 1) size = size >> 1;
      return SLOT_W'(size - 1);
   endfunction

   function automatic logic [SLOT_W-1:0] batch_len();
      logic [COUNT_W-1:0] b;
      b = batch_reg;
      if (b < BATCH_MIN) b = BATCH_MIN;
      if (b > BATCH_MAX) b = BATCH_MAX;
      return SLOT_W'(b);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (fail_count < PRINT_LIMIT)
         $display("%0t mismatch: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) report_mismatch(what, want, got);
   endtask

   // The previous result of a request is pushed when a new one comes, so
   // the final one can still get its last flag.
   task automatic stage_event(input kind_type kind, input logic [SLOT_W-1:0] slot,
                              input logic [ADDR_W-1:0] addr,
                              input logic [CTRL_W-1:0] ctrl,
                              input logic [COUNT_W-1:0] freed, input logic err);
      if (staged_count > 0) ring_events_due.push_back(staged_event);
      staged_event.kind  = kind;
      staged_event.slot  = slot;
      staged_event.addr  = addr;
      staged_event.ctrl  = ctrl;
      staged_event.freed = freed;
      staged_event.err   = err;
      staged_event.last  = 1'b0;
      staged_count++;
   endtask

   // Frees whole batches while enough slots are in flight and the batch's
   // final slot is done. A hole inside a batch stops the count but the clean
   // index still moves past the whole batch.
   task automatic free_batches(input logic [SLOT_W-1:0] mask);
      logic [SLOT_W-1:0]  clean;
      logic [SLOT_W-1:0]  tail;
      logic [SLOT_W-1:0]  batch;
      logic [SLOT_W-1:0]  stop_at;
      logic [COUNT_W-1:0] freed;
      logic               err;
      clean = clean_ptr & mask;
      tail  = tail_ptr & mask;
      batch = batch_len();
      while (((tail - clean) & mask) >= batch) begin
         stop_at = (clean + batch - 1'b1) & mask;
         if (!done_bits[stop_at]) break;
         freed = '0;
         err   = 1'b0;
         for (int k = 0; k < batch; k++) begin
            if (!done_bits[(clean + k) & mask]) begin
               err = 1'b1;
               break;
            end
            freed++;
         end
         stage_event(KIND_BATCH, clean, '0, '0, freed, err);
         clean = (stop_at + 1'b1) & mask;
      end
      clean_ptr = clean;
      tail_ptr  = tail;
   endtask

   task automatic predict_request(input action_type act, input logic [QID_W-1:0] qid,
                                  input logic start, input logic endc,
                                  input logic [ADDR_W-1:0] addr,
                                  input logic [LEN_W-1:0] len,
                                  input logic [SLOT_W-1:0] didx);
      logic [SLOT_W-1:0] mask;
      logic [SLOT_W-1:0] tail;
      logic [SLOT_W-1:0] next_tail;
      mask = slot_mask();
      staged_count = 0;
      if (act == ACT_DONE) begin
         done_bits[didx & mask] = 1'b1;
      end else if (act != ACT_NONE) begin
         if (qid != '0) begin
            stage_event(KIND_REFUSED, '0, '0, '0, '0, 1'b0);
         end else begin
            if (act == ACT_CALL || start) free_batches(mask);
            if (act == ACT_SUBMIT) begin
               tail      = tail_ptr & mask;
               next_tail = (tail + 1'b1) & mask;
               // One slot always stays empty, so a full ring refuses.
               if ((clean_ptr & mask) == next_tail) begin
                  stage_event(KIND_REFUSED, tail, '0, '0, '0, 1'b0);
               end else begin
                  stage_event(KIND_DESC, tail, addr, CMD_BITS | CTRL_W'(len), '0, 1'b0);
                  done_bits[tail] = 1'b0;
                  tail_ptr = next_tail;
               end
            end
            if (act == ACT_CALL || endc)
               stage_event(KIND_TAIL, tail_ptr & mask, '0, '0, '0, 1'b0);
         end
      end
      if (staged_count > 0) begin
         staged_event.last = 1'b1;
         ring_events_due.push_back(staged_event);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) done_bits[i] = 1'b0;
         tail_ptr      = '0;
         clean_ptr     = '0;
         size_log2_reg = LG_AT_RESET;
         batch_reg     = BATCH_AT_RESET;
         fail_count    = 0;
         ring_events_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (ring_events_due.size() == 0) begin
               report_mismatch("result with no request waiting, kind", '0, rsp_tuser);
            end else begin
               want = ring_events_due.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("slot_index", want.slot, rsp_tdata[8:0]);
               check_field("descriptor_address", want.addr, rsp_tdata[72:9]);
               check_field("descriptor_control", want.ctrl, rsp_tdata[104:73]);
               check_field("freed_count", want.freed, rsp_tdata[111:105]);
               check_field("ring_error", want.err, rsp_tdata[112]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RING_SIZE_LOG2) size_log2_reg = csr_data[LG_W-1:0];
            else batch_reg = csr_data;
         end
         if (req_tvalid && req_tready)
            predict_request(action_type'(req_tuser[1:0]), req_tdata[7:0], req_tuser[2],
                            req_tlast, req_tdata[71:8], req_tdata[87:72],
                            req_tdata[96:88]);
      end
      pending    <= ring_events_due.size();
      ring_mask  <= slot_mask();
      ring_tail  <= tail_ptr & slot_mask();
      ring_clean <= clean_ptr & slot_mask();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the transmit descriptor ring with batched cleanup
// Drives requests and register writes, stalls the result side, and runs a
// directed opening followed by random phases over several ring and batch
// settings. Checking is done by the ring monitor beside the block.
// ----------------------------------------------------------------------------

module tb_top
   import txdr_pkg::*;
();

   localparam int RING_DEPTH  = 512;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 40;
   localparam int PHASE_ITEMS = 45;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic [103:0]   req_tdata = '0;
   logic [2:0]     req_tuser = '0;
   logic           req_tlast = 1'b0;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [119:0]   rsp_tdata;
   logic [1:0]     rsp_tuser;
   logic           rsp_tlast;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b1;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [0:0]     csr_index = '0;
   logic [6:0]     csr_data = '0;

   int             fail_count;
   int             pending;
   logic [SLOT_W-1:0] ring_tail;
   logic [SLOT_W-1:0] ring_clean;
   logic [SLOT_W-1:0] ring_mask;

   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             req_count = 0;
   int             cycle_count = 0;
   logic [SLOT_W-1:0] wb_ptr = '0;
   logic [SLOT_W-1:0] late_slot = '0;
   logic           late_valid = 1'b0;

   tx_descriptor_ring_batched_clean #(.RING_DEPTH(RING_DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   txdr_ring_monitor #(.RING_DEPTH(RING_DEPTH)) ring_monitor (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending),
      .ring_tail(ring_tail), .ring_clean(ring_clean), .ring_mask(ring_mask)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Valid stays high from one request to the next unless a gap is taken,
   // so it never gets two assignments in one step.
   task automatic send_req(input action_type act, input logic [QID_W-1:0] qid,
                           input logic start, input logic endc,
                           input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len,
                           input logic [SLOT_W-1:0] didx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tdata  <= {7'b0, didx, len, addr, qid};
      req_tuser  <= {start, act};
      req_tlast  <= endc;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (act != ACT_NONE) req_count++;
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [6:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Holds off new requests until every expected result is back, then lets
   // done write-backs that produce nothing drain out of the block.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic submit_call(input int n_pkts);
      logic [QID_W-1:0] qid;
      for (int i = 0; i < n_pkts; i++) begin
         qid = ($urandom_range(29) == 0) ? QID_W'($urandom_range(1, 255)) : '0;
         send_req(ACT_SUBMIT, qid, (i == 0) && ($urandom_range(9) != 0), i == n_pkts - 1,
                  rand_word(), LEN_W'($urandom_range(16'hFFFF)),
                  SLOT_W'($urandom_range(511)));
      end
   endtask

   // Write-backs follow the queued slots in order. Now and then one slot is
   // held back and written late, which leaves a hole in a cleanup batch.
   task automatic write_backs(input int count);
      if (late_valid) begin
         send_req(ACT_DONE, QID_W'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), rand_word(), LEN_W'($urandom_range(16'hFFFF)),
                  late_slot);
         late_valid = 1'b0;
      end
      while (count > 0 && wb_ptr != ring_tail) begin
         if (!late_valid && $urandom_range(11) == 0) begin
            late_slot  = wb_ptr;
            late_valid = 1'b1;
         end else begin
            send_req(ACT_DONE, QID_W'($urandom_range(255)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), rand_word(), LEN_W'($urandom_range(16'hFFFF)),
                     wb_ptr);
         end
         wb_ptr = (wb_ptr + 1'b1) & ring_mask;
         count--;
      end
   endtask

   initial begin
      int          goal;
      int          pick;
      int          n_pkts;
      logic [6:0]  lg_value;
      logic [6:0]  batch_value;
      logic [QID_W-1:0] qid;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The block clears its done bits after reset before taking requests.
      while (!req_tready) @(posedge clock);

      // Directed opening at the reset settings.
      send_req(ACT_SUBMIT, 8'd0, 1'b1, 1'b1, 64'd0, 16'd0, 9'd0);
      send_req(ACT_SUBMIT, 8'd0, 1'b0, 1'b0, '1, 16'hFFFF, 9'd511);
      send_req(ACT_SUBMIT, 8'd255, 1'b1, 1'b1, rand_word(), 16'h1234, 9'd0);
      send_req(ACT_CALL, 8'd0, 1'b0, 1'b0, 64'd0, 16'd0, 9'd0);
      send_req(ACT_CALL, 8'd1, 1'b1, 1'b1, '1, 16'hFFFF, 9'd511);
      send_req(ACT_NONE, 8'd0, 1'b1, 1'b1, rand_word(), 16'h5555, 9'd3);
      send_req(ACT_NONE, 8'd200, 1'b0, 1'b0, '1, 16'hFFFF, 9'd511);
      send_req(ACT_DONE, 8'd255, 1'b1, 1'b1, '1, 16'hFFFF, 9'd511);
      send_req(ACT_DONE, 8'd0, 1'b0, 1'b0, 64'd0, 16'd0, 9'd0);
      send_req(ACT_DONE, 8'd0, 1'b0, 1'b0, 64'd0, 16'd0, 9'd1);
      send_req(ACT_SUBMIT, 8'h80, 1'b0, 1'b1, rand_word(), 16'h8000, 9'd256);
      send_req(ACT_CALL, 8'd0, 1'b1, 1'b0, rand_word(), 16'd1, 9'd2);
      send_req(ACT_SUBMIT, 8'd0, 1'b1, 1'b0, 64'h8000_0000_0000_0001, 16'h0001, 9'd0);
      send_req(ACT_SUBMIT, 8'd0, 1'b0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 16'hFFFE, 9'd0);

      for (int ph = 0; ph < 6; ph++) begin
         unique case (ph)
            0: begin lg_value = 7'd6;   batch_value = 7'd16;  end
            1: begin lg_value = 7'h73;  batch_value = 7'd5;   end
            2: begin lg_value = 7'd9;   batch_value = 7'd64;  end
            3: begin lg_value = 7'd7;   batch_value = 7'd127; end
            4: begin lg_value = 7'h0F;  batch_value = 7'd0;   end
            default: begin lg_value = 7'd8; batch_value = 7'd24; end
         endcase
         wait_drain();
         write_csr(CSR_RING_SIZE_LOG2, lg_value);
         write_csr(CSR_CLEAN_BATCH, batch_value);
         unique case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         wb_ptr     = ring_clean;
         late_valid = 1'b0;
         goal       = req_count + PHASE_ITEMS;
         // A long call with nothing written back runs the small ring full.
         if (ph == 0) submit_call(70);
         while (req_count < goal) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               pick = $urandom_range(99);
               if (pick < 70) n_pkts = $urandom_range(1, 8);
               else if (pick < 90) n_pkts = $urandom_range(9, 24);
               else n_pkts = $urandom_range(40, 70);
               submit_call(n_pkts);
               write_backs($urandom_range(40));
            end else if (pick < 70) begin
               send_req(ACT_CALL, 8'd0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        rand_word(), LEN_W'($urandom_range(16'hFFFF)),
                        SLOT_W'($urandom_range(511)));
            end else if (pick < 85) begin
               write_backs($urandom_range(1, 40));
            end else begin
               qid = ($urandom_range(1) == 0) ? '0 : QID_W'($urandom_range(1, 255));
               send_req(action_type'($urandom_range(3)), qid, 1'($urandom_range(1)),
                        1'($urandom_range(1)), rand_word(), LEN_W'($urandom_range(16'hFFFF)),
                        SLOT_W'($urandom_range(511)));
            end
         end
      end

      wait_drain();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
